// ===== hw/rtl/rbd_pkg.sv =====
// ----------------------------------------------------------------------------
// rbd_pkg: shared types and helpers for the RGB565 2x2 box downscaler
// Item structs, configuration layout, channel widening functions.
// ----------------------------------------------------------------------------
package rbd_pkg;

    localparam int MAX_LINE_PIXELS_DEF  = 256;
    localparam int COL_W                = 8;
    localparam int ROW_W                = 8;
    localparam int COL_SPAN             = 1 << COL_W;
    localparam int SUM_W                = 9;
    localparam int CH_W                 = 8;
    localparam int CFG_INDEX_W          = 2;
    localparam int CFG_DATA_W           = 9;

    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_PIXELS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OUT_COLS    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_OUT_ROWS    = 2'd2;

    localparam logic [8:0] LINE_PIXELS_RST   = 9'd96;
    localparam logic [7:0] OUT_COLS_RST      = 8'd48;
    localparam logic [7:0] OUT_ROWS_RST      = 8'd48;
    localparam logic [8:0] ROW_LEN_MIN       = 9'd2;
    localparam logic [ROW_W-1:0] ROW_LAST    = 8'd255;

    typedef struct packed {
        logic [15:0] pixel;
        logic        frame_start;
    } cam_item_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            frame_done;
    } blk_item_t;

    typedef struct packed {
        logic [SUM_W-1:0] r;
        logic [SUM_W-1:0] g;
        logic [SUM_W-1:0] b;
    } sum_t;

    typedef struct packed {
        logic frame_done;
        sum_t bottom;
    } stage_t;

    typedef struct packed {
        logic [8:0] line_pixels;
        logic [7:0] out_cols;
        logic [7:0] out_rows;
    } cfg_t;

    // floor(v*255/31) = 8v + floor(7v/31); the fraction steps at fixed thresholds
    function automatic logic [CH_W-1:0] expand5(input logic [4:0] v);
        logic [2:0] f;
        f = 3'd0;
        if (v >= 5'd5)  f = 3'd1;
        if (v >= 5'd9)  f = 3'd2;
        if (v >= 5'd14) f = 3'd3;
        if (v >= 5'd18) f = 3'd4;
        if (v >= 5'd23) f = 3'd5;
        if (v >= 5'd27) f = 3'd6;
        if (v >= 5'd31) f = 3'd7;
        return {v, 3'b000} + {5'b00000, f};
    endfunction

    // floor(v*255/63) = 4v + floor(v/21)
    function automatic logic [CH_W-1:0] expand6(input logic [5:0] v);
        logic [1:0] f;
        f = 2'd0;
        if (v >= 6'd21) f = 2'd1;
        if (v >= 6'd42) f = 2'd2;
        if (v >= 6'd63) f = 2'd3;
        return {v, 2'b00} + {6'b000000, f};
    endfunction

endpackage

// ===== hw/rtl/rbd_ram.sv =====
// ----------------------------------------------------------------------------
// rbd_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module rbd_ram #(
    parameter int WIDTH = 27,
    parameter int DEPTH = 128,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/rbd_accum.sv =====
// ----------------------------------------------------------------------------
// rbd_accum: position tracking, channel widening and pair accumulation
// Writes top-row pair sums to the line store, issues reads on bottom rows.
// ----------------------------------------------------------------------------
module rbd_accum #(
    parameter int ROW_CAP = rbd_pkg::MAX_LINE_PIXELS_DEF,
    parameter int ADDR_W  = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rbd_pkg::cfg_t       cfg,
    input  logic                cam_valid,
    output logic                cam_ready,
    input  rbd_pkg::cam_item_t  cam_item,
    input  logic                s1_move,
    output logic                s1_valid,
    output rbd_pkg::stage_t     s1_data,
    output logic                ram_we,
    output logic                ram_re,
    output logic [ADDR_W-1:0]   ram_addr,
    output rbd_pkg::sum_t       ram_wdata
);

    localparam logic [8:0] ROW_CAP_V = 9'(ROW_CAP);

    logic [rbd_pkg::COL_W-1:0] col_reg, col_next;
    logic [rbd_pkg::ROW_W-1:0] row_reg, row_next;
    rbd_pkg::sum_t             pair_reg, pair_next;
    logic                      s1_valid_reg, s1_valid_next;
    rbd_pkg::stage_t           s1_data_reg, s1_data_next;

    logic                      accept;
    logic [rbd_pkg::COL_W-1:0] col;
    logic [rbd_pkg::ROW_W-1:0] row;
    logic [6:0]                bx;
    logic [6:0]                by;
    logic                      wanted;
    logic                      done;
    logic [rbd_pkg::CH_W-1:0]  r8, g8, b8;
    rbd_pkg::sum_t             pix, pair_sum;
    logic [8:0]                len;
    logic                      row_end;

    assign cam_ready = !s1_valid_reg || s1_move;
    assign accept    = cam_valid && cam_ready;

    always_comb
    begin
        col = cam_item.frame_start ? '0 : col_reg;
        row = cam_item.frame_start ? '0 : row_reg;
        bx  = col[rbd_pkg::COL_W-1:1];
        by  = row[rbd_pkg::ROW_W-1:1];
        wanted = ({1'b0, bx} < cfg.out_cols) && ({1'b0, by} < cfg.out_rows);
        done   = (({1'b0, bx} + 8'd1) == cfg.out_cols) &&
                 (({1'b0, by} + 8'd1) == cfg.out_rows);

        r8 = rbd_pkg::expand5(cam_item.pixel[15:11]);
        g8 = rbd_pkg::expand6(cam_item.pixel[10:5]);
        b8 = rbd_pkg::expand5(cam_item.pixel[4:0]);
        pix.r = {1'b0, r8};
        pix.g = {1'b0, g8};
        pix.b = {1'b0, b8};
        pair_sum.r = pair_reg.r + pix.r;
        pair_sum.g = pair_reg.g + pix.g;
        pair_sum.b = pair_reg.b + pix.b;

        // effective row length clamped to [2, cap]
        if (cfg.line_pixels < rbd_pkg::ROW_LEN_MIN)
            len = rbd_pkg::ROW_LEN_MIN;
        else if (cfg.line_pixels > ROW_CAP_V)
            len = ROW_CAP_V;
        else
            len = cfg.line_pixels;
        row_end = ({1'b0, col} + 9'd1) >= len;
    end

    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        pair_next     = pair_reg;
        s1_valid_next = s1_valid_reg;
        s1_data_next  = s1_data_reg;
        if (accept)
        begin
            pair_next = col[0] ? pair_sum : pix;
            if (row_end)
            begin
                col_next = '0;
                row_next = (row != rbd_pkg::ROW_LAST) ? row + 8'd1 : row;
            end
            else
            begin
                col_next = col + 8'd1;
                row_next = row;
            end
            s1_valid_next     = col[0] && row[0] && wanted;
            s1_data_next      = {done, pair_sum};
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
    end

    assign ram_we    = accept && col[0] && !row[0] && wanted;
    assign ram_re    = accept && col[0] && row[0] && wanted;
    assign ram_addr  = bx[ADDR_W-1:0];
    assign ram_wdata = pair_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            pair_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            pair_reg     <= pair_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_data_reg <= s1_data_next;
    end

    assign s1_valid = s1_valid_reg;
    assign s1_data  = s1_data_reg;

endmodule

// ===== hw/rtl/rbd_emit.sv =====
// ----------------------------------------------------------------------------
// rbd_emit: block sum and average, output register
// Adds the stored top-row pair to the bottom pair and holds the result item.
// ----------------------------------------------------------------------------
module rbd_emit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s1_valid,
    input  rbd_pkg::stage_t     s1_data,
    input  rbd_pkg::sum_t       ram_rdata,
    output logic                s1_move,
    output logic                blk_valid,
    input  logic                blk_ready,
    output rbd_pkg::blk_item_t  blk_item
);

    logic                blk_valid_reg, blk_valid_next;
    rbd_pkg::blk_item_t  blk_item_reg, blk_item_next;
    logic [9:0]          sr, sg, sb;

    assign s1_move = !blk_valid_reg || blk_ready;

    always_comb
    begin
        sr = {1'b0, ram_rdata.r} + {1'b0, s1_data.bottom.r};
        sg = {1'b0, ram_rdata.g} + {1'b0, s1_data.bottom.g};
        sb = {1'b0, ram_rdata.b} + {1'b0, s1_data.bottom.b};
    end

    always_comb
    begin
        blk_valid_next = s1_move ? s1_valid : blk_valid_reg;
        blk_item_next  = blk_item_reg;
        if (s1_move && s1_valid)
        begin
            blk_item_next.red        = sr[9:2];
            blk_item_next.green      = sg[9:2];
            blk_item_next.blue       = sb[9:2];
            blk_item_next.frame_done = s1_data.frame_done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_valid_reg <= 1'b0;
        end
        else
        begin
            blk_valid_reg <= blk_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_item_reg <= blk_item_next;
    end

    assign blk_valid = blk_valid_reg;
    assign blk_item  = blk_item_reg;

endmodule

// ===== hw/rtl/rgb565_box_downscale_2x_core.sv =====
// ----------------------------------------------------------------------------
// rgb565_box_downscale_2x_core: 2x2 box downscaler, RGB565 in, RGB888 out
// Throughput: one pixel item per cycle, with or without results, unless
// blk_ready stalls the output and holds off cam_ready. Pipeline: two register
// stages (line store read, then output register) lie between a bottom-right
// pixel and its block item. Reset: position, pair sum, config, handshake state
// reset at once; the line store is not cleared, entries undefined until written.
// ----------------------------------------------------------------------------
module rgb565_box_downscale_2x_core #(
    parameter int MAX_LINE_PIXELS = rbd_pkg::MAX_LINE_PIXELS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cam_valid,
    output logic                               cam_ready,
    input  rbd_pkg::cam_item_t                 cam_item,
    output logic                               blk_valid,
    input  logic                               blk_ready,
    output rbd_pkg::blk_item_t                 blk_item,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rbd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rbd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int ROW_CAP = (MAX_LINE_PIXELS > rbd_pkg::COL_SPAN) ? rbd_pkg::COL_SPAN :
                             ((MAX_LINE_PIXELS < 2) ? 2 : MAX_LINE_PIXELS);
    localparam int DEPTH   = (ROW_CAP + 1) / 2;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    rbd_pkg::cfg_t    cfg_reg, cfg_next;
    logic             s1_move;
    logic             s1_valid;
    rbd_pkg::stage_t  s1_data;
    logic             ram_we;
    logic             ram_re;
    logic [ADDR_W-1:0] ram_addr;
    rbd_pkg::sum_t    ram_wdata;
    rbd_pkg::sum_t    ram_rdata;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rbd_pkg::CFG_LINE_PIXELS: cfg_next.line_pixels = cfg_data;
                rbd_pkg::CFG_OUT_COLS:    cfg_next.out_cols    = cfg_data[7:0];
                rbd_pkg::CFG_OUT_ROWS:    cfg_next.out_rows    = cfg_data[7:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_pixels <= rbd_pkg::LINE_PIXELS_RST;
            cfg_reg.out_cols    <= rbd_pkg::OUT_COLS_RST;
            cfg_reg.out_rows    <= rbd_pkg::OUT_ROWS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rbd_accum #(
        .ROW_CAP (ROW_CAP),
        .ADDR_W  (ADDR_W)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cam_valid (cam_valid),
        .cam_ready (cam_ready),
        .cam_item  (cam_item),
        .s1_move   (s1_move),
        .s1_valid  (s1_valid),
        .s1_data   (s1_data),
        .ram_we    (ram_we),
        .ram_re    (ram_re),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata)
    );

    rbd_ram #(
        .WIDTH  ($bits(rbd_pkg::sum_t)),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_line (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    rbd_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_valid  (s1_valid),
        .s1_data   (s1_data),
        .ram_rdata (ram_rdata),
        .s1_move   (s1_move),
        .blk_valid (blk_valid),
        .blk_ready (blk_ready),
        .blk_item  (blk_item)
    );

endmodule

// ===== tb/rbd_checker.sv =====
// ----------------------------------------------------------------------------
// rbd_checker: scoreboard for the RGB565 2x2 box downscaler
// Watches the pixel, block and config channels, tracks the raster position
// and block sums, and compares every block item with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rbd_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cam_valid,
    input  logic                            cam_ready,
    input  rbd_pkg::cam_item_t              cam_item,
    input  logic                            blk_valid,
    input  logic                            blk_ready,
    input  rbd_pkg::blk_item_t              blk_item,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [rbd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rbd_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              errors,
    output int                              outstanding
);

    localparam int ROW_CAP = (rbd_pkg::MAX_LINE_PIXELS_DEF < rbd_pkg::COL_SPAN) ?
                             rbd_pkg::MAX_LINE_PIXELS_DEF : rbd_pkg::COL_SPAN;
    localparam int SLOTS   = rbd_pkg::COL_SPAN / 2;

    rbd_pkg::cfg_t             cfg;
    logic [rbd_pkg::COL_W-1:0] col_pos;
    logic [rbd_pkg::ROW_W-1:0] row_pos;
    rbd_pkg::sum_t             pair_acc;
    rbd_pkg::sum_t             upper_sums [SLOTS];
    rbd_pkg::blk_item_t        block_avg_q [$];

    // truncating widen of a 5- or 6-bit channel code to 8 bits
    function automatic logic [rbd_pkg::SUM_W-1:0] widen(input int code, input int full);
        int v;
        v = (code * 255) / full;
        return v[rbd_pkg::SUM_W-1:0];
    endfunction

    task automatic downscale_pixel(input rbd_pkg::cam_item_t px);
        logic [rbd_pkg::COL_W-1:0] col;
        logic [rbd_pkg::ROW_W-1:0] row;
        int                        bx;
        int                        by;
        int                        len;
        int                        sr;
        int                        sg;
        int                        sb;
        bit                        wanted;
        logic [rbd_pkg::SUM_W-1:0] r8;
        logic [rbd_pkg::SUM_W-1:0] g8;
        logic [rbd_pkg::SUM_W-1:0] b8;
        rbd_pkg::blk_item_t        avg;

        if (px.frame_start)
        begin
            col_pos = '0;
            row_pos = '0;
        end
        col = col_pos;
        row = row_pos;
        bx = (int'(col) >> 1) & (SLOTS - 1);
        by = int'(row) >> 1;
        wanted = (bx < int'(cfg.out_cols)) && (by < int'(cfg.out_rows));
        r8 = widen(int'(px.pixel[15:11]), 31);
        g8 = widen(int'(px.pixel[10:5]), 63);
        b8 = widen(int'(px.pixel[4:0]), 31);

        if (!col[0])
        begin
            pair_acc.r = r8;
            pair_acc.g = g8;
            pair_acc.b = b8;
        end
        else
        begin
            pair_acc.r = pair_acc.r + r8;
            pair_acc.g = pair_acc.g + g8;
            pair_acc.b = pair_acc.b + b8;
            if (!row[0])
            begin
                if (wanted)
                    upper_sums[bx] = pair_acc;
            end
            else if (wanted)
            begin
                sr = int'(upper_sums[bx].r) + int'(pair_acc.r);
                sg = int'(upper_sums[bx].g) + int'(pair_acc.g);
                sb = int'(upper_sums[bx].b) + int'(pair_acc.b);
                avg.red   = 8'(sr / 4);
                avg.green = 8'(sg / 4);
                avg.blue  = 8'(sb / 4);
                avg.frame_done = (bx + 1 == int'(cfg.out_cols)) &&
                                 (by + 1 == int'(cfg.out_rows));
                block_avg_q.push_back(avg);
            end
        end

        len = int'(cfg.line_pixels);
        if (len < 2)
            len = 2;
        if (len > ROW_CAP)
            len = ROW_CAP;
        if (int'(col) + 1 >= len)
        begin
            col_pos = '0;
            if (row < rbd_pkg::ROW_LAST)
                row_pos = row + 1'b1;
        end
        else
        begin
            col_pos = col + 1'b1;
        end
    endtask

    task automatic check_block(input rbd_pkg::blk_item_t got);
        rbd_pkg::blk_item_t want;

        if (block_avg_q.size() == 0)
        begin
            $display("%0t: block item with none expected: r %0d g %0d b %0d done %0d",
                     $time, got.red, got.green, got.blue, got.frame_done);
            errors = errors + 1;
        end
        else
        begin
            want = block_avg_q.pop_front();
            if (got.red !== want.red)
            begin
                $display("%0t: red expected %0d got %0d", $time, want.red, got.red);
                errors = errors + 1;
            end
            if (got.green !== want.green)
            begin
                $display("%0t: green expected %0d got %0d", $time, want.green, got.green);
                errors = errors + 1;
            end
            if (got.blue !== want.blue)
            begin
                $display("%0t: blue expected %0d got %0d", $time, want.blue, got.blue);
                errors = errors + 1;
            end
            if (got.frame_done !== want.frame_done)
            begin
                $display("%0t: frame_done expected %0d got %0d",
                         $time, want.frame_done, got.frame_done);
                errors = errors + 1;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg.line_pixels = rbd_pkg::LINE_PIXELS_RST;
            cfg.out_cols    = rbd_pkg::OUT_COLS_RST;
            cfg.out_rows    = rbd_pkg::OUT_ROWS_RST;
            col_pos  = '0;
            row_pos  = '0;
            pair_acc = '0;
            block_avg_q.delete();
            errors = 0;
            outstanding <= 0;
        end
        else
        begin
            if (blk_valid && blk_ready)
                check_block(blk_item);
            // a pixel taken at this edge still sees the old register values
            if (cam_valid && cam_ready)
                downscale_pixel(cam_item);
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    rbd_pkg::CFG_LINE_PIXELS: cfg.line_pixels = cfg_data[8:0];
                    rbd_pkg::CFG_OUT_COLS:    cfg.out_cols    = cfg_data[7:0];
                    rbd_pkg::CFG_OUT_ROWS:    cfg.out_rows    = cfg_data[7:0];
                    default: ;
                endcase
            end
            outstanding <= block_avg_q.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for the RGB565 2x2 box downscaler
// Directed tiny frames, then random frames over a range of row and target
// sizes, with random gaps on both channels and two long output hold-offs.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cam_valid = 1'b0;
    logic                            cam_ready;
    rbd_pkg::cam_item_t              cam_item = '0;
    logic                            blk_valid;
    logic                            blk_ready = 1'b0;
    rbd_pkg::blk_item_t              blk_item;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [rbd_pkg::CFG_INDEX_W-1:0] cfg_index = rbd_pkg::CFG_LINE_PIXELS;
    logic [rbd_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    int errors;
    int outstanding;
    int sent = 0;

    rgb565_box_downscale_2x_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cam_valid (cam_valid),
        .cam_ready (cam_ready),
        .cam_item  (cam_item),
        .blk_valid (blk_valid),
        .blk_ready (blk_ready),
        .blk_item  (blk_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rbd_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cam_valid   (cam_valid),
        .cam_ready   (cam_ready),
        .cam_item    (cam_item),
        .blk_valid   (blk_valid),
        .blk_ready   (blk_ready),
        .blk_item    (blk_item),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #200000;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send_pixel(input logic [15:0] pixel, input logic frame_start);
        // items 600..799 go out back to back
        while (!(sent >= 600 && sent < 800) && $urandom_range(99) < 38)
        begin
            cam_valid <= 1'b0;
            @(posedge clk);
        end
        cam_valid <= 1'b1;
        cam_item.pixel <= pixel;
        cam_item.frame_start <= frame_start;
        @(posedge clk);
        while (!cam_ready)
            @(posedge clk);
        sent = sent + 1;
    endtask

    task automatic write_reg(input logic [rbd_pkg::CFG_INDEX_W-1:0] index, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value[rbd_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // stop offering pixels, let all block items drain, then idle before returning
    task automatic drain_blocks();
        cam_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_geometry(input int sw, input int tw, input int th);
        write_reg(rbd_pkg::CFG_LINE_PIXELS, sw);
        write_reg(rbd_pkg::CFG_OUT_COLS, tw);
        write_reg(rbd_pkg::CFG_OUT_ROWS, th);
    endtask

    task automatic send_quad(input logic [15:0] p0, input logic [15:0] p1,
                             input logic [15:0] p2, input logic [15:0] p3);
        send_pixel(p0, 1'b1);
        send_pixel(p1, 1'b0);
        send_pixel(p2, 1'b0);
        send_pixel(p3, 1'b0);
    endtask

    function automatic logic [15:0] rand_pixel();
        logic [15:0] p;
        case ($urandom_range(9))
            0: p = 16'h0000;
            1: p = 16'hFFFF;
            2: p = {$urandom_range(1) ? 5'h1F : 5'h00,
                    $urandom_range(1) ? 6'h3F : 6'h00,
                    $urandom_range(1) ? 5'h1F : 5'h00};
            default: p = 16'($urandom);
        endcase
        return p;
    endfunction

    // frames with random content, some cut short; multi-frame runs also get stray frame starts
    task automatic run_frames(input int sw, input int tw, input int th, input int n,
                              input bit single_frame);
        int   len;
        int   frame_len;
        int   pos;
        logic fs;

        set_geometry(sw, tw, th);
        len = (sw < 2) ? 2 : ((sw > 256) ? 256 : sw);
        pos = 0;
        frame_len = 0;
        for (int i = 0; i < n; i++)
        begin
            if (single_frame)
            begin
                frame_len = n;
            end
            else if (pos >= frame_len)
            begin
                pos = 0;
                frame_len = len * 2 * ((th < 1) ? 1 : th) + $urandom_range(0, 2 * len);
                if ($urandom_range(3) == 0)
                    frame_len = $urandom_range(1, frame_len);
            end
            fs = (pos == 0) || (!single_frame && $urandom_range(63) == 0);
            if (fs)
                pos = 0;
            send_pixel(rand_pixel(), fs);
            pos = pos + 1;
        end
        drain_blocks();
    endtask

    initial
    begin : stimulus
        int start_count;
        int waited;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 2x2 source, one block per frame
        set_geometry(2, 1, 1);
        send_quad(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_quad(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_quad(16'hF800, 16'h07E0, 16'h001F, 16'hFFFF);
        send_quad(16'h0821, 16'hF7DE, 16'h8410, 16'h7BEF);
        // rows past the target height are dropped
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'h1234, 1'b0);
        send_pixel(16'hABCD, 1'b0);
        send_pixel(16'h5555, 1'b0);
        // restart in the middle of a block
        send_pixel(16'hFFFF, 1'b1);
        send_pixel(16'h0841, 1'b1);
        send_pixel(16'hA514, 1'b0);
        send_pixel(16'h5AEB, 1'b0);
        send_pixel(16'hFFE0, 1'b0);
        drain_blocks();

        start_count = sent;
        run_frames(96, 48, 48, 120, 1'b1);
        run_frames(256, 2, 1, 258, 1'b1);
        // narrow and tall: runs past row 255 where the row count saturates
        run_frames(2, 1, 128, 520, 1'b1);
        // targets far beyond the source
        run_frames(8, 128, 128, 30, 1'b0);
        run_frames(5, 2, 3, 20, 1'b0);
        run_frames(0, 1, 2, 12, 1'b0);
        run_frames(6, 0, 2, 10, 1'b0);
        while (sent - start_count < 1000)
            run_frames($urandom_range(0, 12), $urandom_range(0, 6), $urandom_range(0, 4),
                       $urandom_range(30, 80), 1'b0);

        waited = 0;
        while (outstanding != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited = waited + 1;
        end
        repeat (8) @(posedge clk);
        if (outstanding != 0)
            $display("%0t: %0d block items never arrived", $time, outstanding);
        if (errors == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : receiver
        int  cycles;
        int  taken;
        int  hold;
        bit  first_hold_done;
        bit  second_hold_done;

        cycles = 0;
        taken = 0;
        hold = 0;
        first_hold_done = 1'b0;
        second_hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cycles = cycles + 1;
            if (blk_valid && blk_ready)
                taken = taken + 1;
            if (!first_hold_done && taken >= 30)
            begin
                first_hold_done = 1'b1;
                hold = 300;
            end
            if (!second_hold_done && taken >= 200)
            begin
                second_hold_done = 1'b1;
                hold = 250;
            end
            if (hold > 0)
            begin
                hold = hold - 1;
                blk_ready <= 1'b0;
            end
            else if (cycles >= 2500 && cycles < 3300)
            begin
                blk_ready <= 1'b1;
            end
            else
            begin
                blk_ready <= ($urandom_range(99) >= 38);
            end
        end
    end

endmodule
